// ===== src/msce_pkg.sv =====
// Shared types and constants of the MIDI state change emitter.
package msce_pkg;

    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MSG_COUNT   = 7;

    typedef enum logic [1:0] {
        ACT_APPLY = 2'd0,
        ACT_PANIC = 2'd1,
        ACT_RESET = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // message slots, in the order they go out; A is the old channel (the word's own channel on panic), B the new one
    typedef enum logic [2:0] {
        MSG_OFF_A     = 3'd0,
        MSG_ALL_OFF_A = 3'd1,
        MSG_OFF_B     = 3'd2,
        MSG_ON        = 3'd3,
        MSG_BEND      = 3'd4,
        MSG_VOL       = 3'd5,
        MSG_FILT      = 3'd6
    } msg_kind_t;

    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL     = 4'hB;
    localparam logic [3:0] ST_BEND     = 4'hE;

    localparam logic [6:0] CC_VOLUME  = 7'd7;
    localparam logic [6:0] CC_FILTER  = 7'd74;
    localparam logic [6:0] CC_ALL_OFF = 7'd123;

    typedef struct packed {
        logic [MSG_COUNT-1:0] mask;
        logic [3:0]           ch_a;
        logic [3:0]           ch_b;
        logic [6:0]           note_old;
        logic [6:0]           note_new;
        logic [6:0]           velocity;
        logic [13:0]          bend;
        logic [6:0]           volume;
        logic [6:0]           filter;
    } plan_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== src/msce_front.sv =====
// Front end: takes input words, tracks voice state and builds a message plan.
module msce_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // voice_active, note_number, note_velocity, bend_value, volume_level,
    // filter_level, channel_index, zero pad
    input  logic [msce_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [msce_pkg::S_TUSER_W-1:0]  s_tuser,
    input  msce_pkg::queue_stat_t           q_stat,
    output logic                            push,
    output msce_pkg::plan_t                 plan
);

    logic        prev_active_reg,   prev_active_next;
    logic [6:0]  prev_note_reg,     prev_note_next;
    logic [13:0] prev_bend_reg,     prev_bend_next;
    logic [6:0]  prev_volume_reg,   prev_volume_next;
    logic [6:0]  prev_filter_reg,   prev_filter_next;
    logic [3:0]  prev_channel_reg,  prev_channel_next;
    logic        channel_known_reg, channel_known_next;

    msce_pkg::action_t action;
    logic        act;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [13:0] bend;
    logic [6:0]  vol;
    logic [6:0]  filt;
    logic [3:0]  ch;
    logic        accept;
    logic        chg;
    logic        eff_active;

    assign action = msce_pkg::action_t'(s_tuser);
    assign act    = s_tdata[0];
    assign note   = s_tdata[7:1];
    assign vel    = s_tdata[14:8];
    assign bend   = s_tdata[28:15];
    assign vol    = s_tdata[35:29];
    assign filt   = s_tdata[42:36];
    assign ch     = s_tdata[46:43];

    assign s_tready   = !q_stat.full;
    assign accept     = s_tvalid && s_tready;
    assign chg        = channel_known_reg && (prev_channel_reg != ch);
    // a channel change wipes the remembered voice before the transition
    assign eff_active = prev_active_reg && !chg;
    assign push       = accept && (plan.mask != '0);

    always_comb
    begin
        plan.mask     = '0;
        plan.ch_a     = prev_channel_reg;
        plan.ch_b     = ch;
        plan.note_old = prev_note_reg;
        plan.note_new = note;
        plan.velocity = vel;
        plan.bend     = bend;
        plan.volume   = vol;
        plan.filter   = filt;

        prev_active_next   = prev_active_reg;
        prev_note_next     = prev_note_reg;
        prev_bend_next     = prev_bend_reg;
        prev_volume_next   = prev_volume_reg;
        prev_filter_next   = prev_filter_reg;
        prev_channel_next  = prev_channel_reg;
        channel_known_next = channel_known_reg;

        unique case (action)
            msce_pkg::ACT_APPLY:
            begin
                plan.mask[msce_pkg::MSG_OFF_A]     = chg && prev_active_reg;
                plan.mask[msce_pkg::MSG_ALL_OFF_A] = chg;
                if (!eff_active && act)
                begin
                    plan.mask[msce_pkg::MSG_ON]   = 1'b1;
                    plan.mask[msce_pkg::MSG_BEND] = 1'b1;
                    plan.mask[msce_pkg::MSG_VOL]  = 1'b1;
                    plan.mask[msce_pkg::MSG_FILT] = 1'b1;
                end
                else if (eff_active && !act)
                begin
                    plan.mask[msce_pkg::MSG_OFF_B] = 1'b1;
                    plan.mask[msce_pkg::MSG_VOL]   = 1'b1;
                    plan.volume                    = '0;
                end
                else if (eff_active && act)
                begin
                    plan.mask[msce_pkg::MSG_OFF_B] = prev_note_reg != note;
                    plan.mask[msce_pkg::MSG_ON]    = prev_note_reg != note;
                    plan.mask[msce_pkg::MSG_BEND]  = prev_bend_reg != bend;
                    plan.mask[msce_pkg::MSG_VOL]   = prev_volume_reg != vol;
                    plan.mask[msce_pkg::MSG_FILT]  = prev_filter_reg != filt;
                end
                prev_active_next   = act;
                prev_note_next     = note;
                prev_bend_next     = bend;
                prev_volume_next   = vol;
                prev_filter_next   = filt;
                prev_channel_next  = ch;
                channel_known_next = 1'b1;
            end
            msce_pkg::ACT_PANIC:
            begin
                plan.ch_a                          = ch;
                plan.mask[msce_pkg::MSG_OFF_A]     = prev_active_reg;
                plan.mask[msce_pkg::MSG_ALL_OFF_A] = 1'b1;
                prev_active_next   = 1'b0;
                prev_note_next     = '0;
                prev_bend_next     = '0;
                prev_volume_next   = '0;
                prev_filter_next   = '0;
                prev_channel_next  = ch;
                channel_known_next = 1'b1;
            end
            msce_pkg::ACT_RESET:
            begin
                prev_active_next   = 1'b0;
                prev_note_next     = '0;
                prev_bend_next     = '0;
                prev_volume_next   = '0;
                prev_filter_next   = '0;
                channel_known_next = 1'b0;
            end
            msce_pkg::ACT_NONE:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_active_reg   <= 1'b0;
            prev_note_reg     <= '0;
            prev_bend_reg     <= '0;
            prev_volume_reg   <= '0;
            prev_filter_reg   <= '0;
            prev_channel_reg  <= '0;
            channel_known_reg <= 1'b0;
        end
        else if (accept)
        begin
            prev_active_reg   <= prev_active_next;
            prev_note_reg     <= prev_note_next;
            prev_bend_reg     <= prev_bend_next;
            prev_volume_reg   <= prev_volume_next;
            prev_filter_reg   <= prev_filter_next;
            prev_channel_reg  <= prev_channel_next;
            channel_known_reg <= channel_known_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("plan pushed into a full queue");

    a_reset_forgets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == msce_pkg::ACT_RESET |=> !channel_known_reg && !prev_active_reg)
        else $error("reset word left voice state behind");
`endif

endmodule

// ===== src/msce_queue.sv =====
// Short plan queue between front and back end.
module msce_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  msce_pkg::plan_t       wr_plan,
    input  logic                  pop,
    output msce_pkg::plan_t       rd_plan,
    output msce_pkg::queue_stat_t stat
);

    msce_pkg::plan_t                entry_reg [msce_pkg::QUEUE_DEPTH];
    logic [msce_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [msce_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [msce_pkg::QCNT_W-1:0]    count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign stat.full  = count_reg == msce_pkg::QCNT_W'(msce_pkg::QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_plan    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_plan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= msce_pkg::QCNT_W'(msce_pkg::QUEUE_DEPTH))
        else $error("queue count past depth");
`endif

endmodule

// ===== src/msce_back.sv =====
// Back end: walks a plan's message mask and drives the output words.
module msce_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  msce_pkg::plan_t                 q_plan,
    input  msce_pkg::queue_stat_t           q_stat,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status_byte, data_first, data_second, zero pad
    output logic [msce_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    msce_pkg::plan_t                cur_reg;
    logic [msce_pkg::MSG_COUNT-1:0] mask_reg, mask_next;
    logic                           out_valid_reg;
    logic [msce_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                           out_last_reg;

    msce_pkg::msg_kind_t            kind;
    logic [msce_pkg::MSG_COUNT-1:0] rest;
    logic                           emit;
    logic [7:0]                     status;
    logic [6:0]                     d1;
    logic [6:0]                     d2;

    // lowest pending slot goes first
    always_comb
    begin
        kind = msce_pkg::MSG_OFF_A;
        for (int i = msce_pkg::MSG_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                kind = msce_pkg::msg_kind_t'(i[2:0]);
            end
        end
    end

    assign rest = mask_reg & ~(msce_pkg::MSG_COUNT'(1) << kind);
    assign emit = (mask_reg != '0) && (!out_valid_reg || m_tready);
    assign pop  = !q_stat.empty && ((mask_reg == '0) || (emit && rest == '0));

    always_comb
    begin
        unique case (kind)
            msce_pkg::MSG_OFF_A:
            begin
                status = {msce_pkg::ST_NOTE_OFF, cur_reg.ch_a};
                d1     = cur_reg.note_old;
                d2     = '0;
            end
            msce_pkg::MSG_ALL_OFF_A:
            begin
                status = {msce_pkg::ST_CTRL, cur_reg.ch_a};
                d1     = msce_pkg::CC_ALL_OFF;
                d2     = '0;
            end
            msce_pkg::MSG_OFF_B:
            begin
                status = {msce_pkg::ST_NOTE_OFF, cur_reg.ch_b};
                d1     = cur_reg.note_old;
                d2     = '0;
            end
            msce_pkg::MSG_ON:
            begin
                status = {msce_pkg::ST_NOTE_ON, cur_reg.ch_b};
                d1     = cur_reg.note_new;
                d2     = cur_reg.velocity;
            end
            msce_pkg::MSG_BEND:
            begin
                status = {msce_pkg::ST_BEND, cur_reg.ch_b};
                d1     = cur_reg.bend[6:0];
                d2     = cur_reg.bend[13:7];
            end
            msce_pkg::MSG_VOL:
            begin
                status = {msce_pkg::ST_CTRL, cur_reg.ch_b};
                d1     = msce_pkg::CC_VOLUME;
                d2     = cur_reg.volume;
            end
            msce_pkg::MSG_FILT:
            begin
                status = {msce_pkg::ST_CTRL, cur_reg.ch_b};
                d1     = msce_pkg::CC_FILTER;
                d2     = cur_reg.filter;
            end
            default:
            begin
                status = '0;
                d1     = '0;
                d2     = '0;
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            mask_next = q_plan.mask;
        end
        else if (emit)
        begin
            mask_next = rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_plan;
        end
        if (emit)
        begin
            out_data_reg <= {2'b00, d2, d1, status};
            out_last_reg <= rest == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_plan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> mask_reg != '0)
        else $error("queued plan carried no messages");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid)
        else $error("emitted word not presented");
`endif

endmodule

// ===== src/midi_state_change_emitter.sv =====
// First message word: after acceptance it passes the plan queue, the back end plan register and the output register.
// Throughput: one input word per cycle while the 4-entry plan queue has room;
// the output side sends one message word per cycle while m_tready is high, and a
// word causes 0 to 6 messages there (back end message walk).
// Reset: rst_n asynchronous active low clears voice state, queue and output valid.
module midi_state_change_emitter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // voice_active, note_number, note_velocity, bend_value, volume_level,
    // filter_level, channel_index, zero pad
    input  logic [msce_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [msce_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status_byte, data_first, data_second, zero pad
    output logic [msce_pkg::M_TDATA_W-1:0]  m_tdata,
    // last_of_run
    output logic                            m_tlast
);

    msce_pkg::plan_t       wr_plan;
    msce_pkg::plan_t       rd_plan;
    msce_pkg::queue_stat_t q_stat;
    logic                  push;
    logic                  pop;

    msce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .plan     (wr_plan)
    );

    msce_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_plan (wr_plan),
        .pop     (pop),
        .rd_plan (rd_plan),
        .stat    (q_stat)
    );

    msce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_plan   (rd_plan),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== verif/msce_checker.sv =====
// Checker for the MIDI state change emitter: predicts message runs and compares the output.
module msce_checker
    import msce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
        logic       last_msg;
    } midi_msg_t;

    midi_msg_t midi_msgs_due[$];

    // remembered voice and channel, as the block should hold them
    logic        voice_on;
    logic [6:0]  voice_note;
    logic [13:0] voice_bend;
    logic [6:0]  voice_vol;
    logic [6:0]  voice_filt;
    logic [3:0]  chan_cur;
    logic        chan_valid;

    midi_msg_t run_buf [6];
    int        run_len;

    task automatic add_msg(input logic [3:0] kind, input logic [3:0] ch,
                           input logic [6:0] d1, input logic [6:0] d2);
        if (run_len < 6)
        begin
            run_buf[run_len] = '{status: {kind, ch}, data1: d1, data2: d2, last_msg: 1'b0};
            run_len++;
        end
    endtask

    task automatic forget_voice();
        voice_on   = 1'b0;
        voice_note = '0;
        voice_bend = '0;
        voice_vol  = '0;
        voice_filt = '0;
    endtask

    task automatic plan_midi_run(input action_t act, input logic on, input logic [6:0] note,
                                 input logic [6:0] vel, input logic [13:0] bend,
                                 input logic [6:0] vol, input logic [6:0] filt,
                                 input logic [3:0] ch);
        midi_msg_t m;
        run_len = 0;
        case (act)
            ACT_APPLY:
            begin
                // moving to another channel silences the old one first
                if (chan_valid && chan_cur != ch)
                begin
                    if (voice_on)
                        add_msg(ST_NOTE_OFF, chan_cur, voice_note, 7'd0);
                    add_msg(ST_CTRL, chan_cur, CC_ALL_OFF, 7'd0);
                    forget_voice();
                end
                chan_cur   = ch;
                chan_valid = 1'b1;
                if (!voice_on && on)
                begin
                    add_msg(ST_NOTE_ON, ch, note, vel);
                    add_msg(ST_BEND, ch, bend[6:0], bend[13:7]);
                    add_msg(ST_CTRL, ch, CC_VOLUME, vol);
                    add_msg(ST_CTRL, ch, CC_FILTER, filt);
                end
                else if (voice_on && !on)
                begin
                    add_msg(ST_NOTE_OFF, ch, voice_note, 7'd0);
                    add_msg(ST_CTRL, ch, CC_VOLUME, 7'd0);
                end
                else if (voice_on && on)
                begin
                    if (voice_note != note)
                    begin
                        add_msg(ST_NOTE_OFF, ch, voice_note, 7'd0);
                        add_msg(ST_NOTE_ON, ch, note, vel);
                    end
                    if (voice_bend != bend)
                        add_msg(ST_BEND, ch, bend[6:0], bend[13:7]);
                    if (voice_vol != vol)
                        add_msg(ST_CTRL, ch, CC_VOLUME, vol);
                    if (voice_filt != filt)
                        add_msg(ST_CTRL, ch, CC_FILTER, filt);
                end
                voice_on   = on;
                voice_note = note;
                voice_bend = bend;
                voice_vol  = vol;
                voice_filt = filt;
            end
            ACT_PANIC:
            begin
                if (voice_on)
                    add_msg(ST_NOTE_OFF, ch, voice_note, 7'd0);
                add_msg(ST_CTRL, ch, CC_ALL_OFF, 7'd0);
                forget_voice();
                chan_cur   = ch;
                chan_valid = 1'b1;
            end
            ACT_RESET:
            begin
                forget_voice();
                chan_valid = 1'b0;
            end
            default:
            begin
                // unused action code: no output, state kept
            end
        endcase
        for (int i = 0; i < run_len; i++)
        begin
            m = run_buf[i];
            m.last_msg = (i == run_len - 1);
            midi_msgs_due.push_back(m);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
                     want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        midi_msg_t want;
        if (!rst_n)
        begin
            midi_msgs_due.delete();
            forget_voice();
            chan_cur    = '0;
            chan_valid  = 1'b0;
            outstanding <= 0;
        end
        else
        begin
            // retire output first so a word arriving on the same edge cannot mask a stray one
            if (m_tvalid && m_tready)
            begin
                if (midi_msgs_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none, actual 0x%0h last %0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = midi_msgs_due.pop_front();
                    check_field("status_byte", want.status, m_tdata[7:0]);
                    check_field("data_first", want.data1, m_tdata[14:8]);
                    check_field("data_second", want.data2, m_tdata[21:15]);
                    check_field("last_of_run", want.last_msg, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                plan_midi_run(action_t'(s_tuser), s_tdata[0], s_tdata[7:1], s_tdata[14:8],
                              s_tdata[28:15], s_tdata[35:29], s_tdata[42:36],
                              s_tdata[46:43]);
            outstanding <= midi_msgs_due.size();
        end
    end

    initial fail_count = 0;

endmodule

// ===== verif/testbench.sv =====
// Top of the MIDI state change emitter testbench: clock, reset, stimulus and verdict.
module testbench;
    import msce_pkg::*;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int fail_count;
    int outstanding;
    int tx_idle_pct = 19;
    int rx_idle_pct = 78;

    // wanted voice carried across random words so most applies are small changes
    logic        w_on;
    logic [6:0]  w_note;
    logic [13:0] w_bend;
    logic [6:0]  w_vol;
    logic [6:0]  w_filt;
    logic [3:0]  w_ch;

    midi_state_change_emitter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    msce_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic send_word(input action_t act, input logic on, input logic [6:0] note,
                             input logic [6:0] vel, input logic [13:0] bend,
                             input logic [6:0] vol, input logic [6:0] filt,
                             input logic [3:0] ch);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, ch, filt, vol, bend, vel, note, on};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic apply_voice(input logic on, input logic [6:0] note, input logic [6:0] vel,
                               input logic [13:0] bend, input logic [6:0] vol,
                               input logic [6:0] filt, input logic [3:0] ch);
        send_word(ACT_APPLY, on, note, vel, bend, vol, filt, ch);
    endtask

    task automatic send_other(input action_t act, input logic [3:0] ch);
        send_word(act, 1'($urandom), 7'($urandom), 7'($urandom), 14'($urandom),
                  7'($urandom), 7'($urandom), ch);
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 82)
        begin
            if ($urandom_range(0, 99) < 10)
                w_ch = 4'($urandom);
            w_on = ($urandom_range(0, 99) < 80);
            if ($urandom_range(0, 99) < 30)
                w_note = 7'($urandom);
            if ($urandom_range(0, 99) < 30)
                w_bend = ($urandom_range(0, 1) != 0) ? 14'($urandom)
                                                    : 14'(8192 + $urandom_range(0, 15) - 8);
            if ($urandom_range(0, 99) < 30)
                w_vol = 7'($urandom);
            if ($urandom_range(0, 99) < 30)
                w_filt = 7'($urandom);
            apply_voice(w_on, w_note, 7'($urandom), w_bend, w_vol, w_filt, w_ch);
        end
        else if (pick < 90)
        begin
            if ($urandom_range(0, 99) < 25)
                w_ch = 4'($urandom);
            send_other(ACT_PANIC, w_ch);
        end
        else if (pick < 95)
            send_other(ACT_RESET, 4'($urandom));
        else
            send_other(ACT_NONE, 4'($urandom));
    endtask

    initial
    begin
        w_on   = 1'b0;
        w_note = 7'd60;
        w_bend = 14'd8192;
        w_vol  = 7'd100;
        w_filt = 7'd64;
        w_ch   = 4'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, each transition, channel moves, panic, reset, unused code
        apply_voice(1'b0, 7'd0, 7'd0, 14'd0, 7'd0, 7'd0, 4'd0);
        apply_voice(1'b1, 7'd0, 7'd0, 14'd0, 7'd0, 7'd0, 4'd0);
        apply_voice(1'b1, 7'd127, 7'd127, 14'd16383, 7'd127, 7'd127, 4'd0);
        apply_voice(1'b1, 7'd127, 7'd127, 14'd16383, 7'd127, 7'd127, 4'd0);
        apply_voice(1'b1, 7'd127, 7'd5, 14'd8192, 7'd127, 7'd127, 4'd0);
        apply_voice(1'b1, 7'd127, 7'd5, 14'd8192, 7'd64, 7'd127, 4'd0);
        apply_voice(1'b1, 7'd127, 7'd5, 14'd8192, 7'd64, 7'd0, 4'd0);
        apply_voice(1'b1, 7'd60, 7'd100, 14'd8192, 7'd64, 7'd0, 4'd0);
        apply_voice(1'b0, 7'd60, 7'd100, 14'd8192, 7'd64, 7'd0, 4'd0);
        apply_voice(1'b0, 7'd61, 7'd100, 14'd1, 7'd1, 7'd1, 4'd0);
        apply_voice(1'b1, 7'd64, 7'd90, 14'd8191, 7'd90, 7'd30, 4'd0);
        apply_voice(1'b1, 7'd65, 7'd80, 14'd8193, 7'd91, 7'd31, 4'd15);
        apply_voice(1'b0, 7'd65, 7'd80, 14'd8193, 7'd91, 7'd31, 4'd15);
        apply_voice(1'b0, 7'd1, 7'd1, 14'd2, 7'd3, 7'd4, 4'd3);
        apply_voice(1'b1, 7'd70, 7'd70, 14'd100, 7'd50, 7'd40, 4'd3);
        send_other(ACT_PANIC, 4'd3);
        send_other(ACT_PANIC, 4'd3);
        apply_voice(1'b1, 7'd72, 7'd33, 14'd9000, 7'd20, 7'd10, 4'd3);
        send_other(ACT_PANIC, 4'd9);
        send_other(ACT_RESET, 4'd9);
        apply_voice(1'b1, 7'd40, 7'd44, 14'd0, 7'd127, 7'd0, 4'd12);
        send_other(ACT_NONE, 4'd5);
        apply_voice(1'b1, 7'd40, 7'd44, 14'd0, 7'd127, 7'd0, 4'd12);
        send_other(ACT_RESET, 4'd0);
        apply_voice(1'b0, 7'd0, 7'd0, 14'd0, 7'd0, 7'd0, 4'd7);
        w_ch = 4'd7;

        for (int i = 0; i < 310; i++)
        begin
            if (i == 103)
            begin
                tx_idle_pct = 78;
                rx_idle_pct = 19;
            end
            else if (i == 206)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_word();
        end
        s_tvalid <= 1'b0;

        // outstanding is registered in the checker, so start looking from the next edge
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
